/* rtl/csalu_pkg.sv */
// ----------------------------------------------------------------------------
// csalu_pkg - shared types and constants for the checked signed ALU
// Operation codes, status codes, the control bundle carried down the pipe.
// ----------------------------------------------------------------------------
package csalu_pkg;

    // Width of the payload fields on the channels
    localparam int FIELD_WIDTH        = 64;
    // Default datapath width
    localparam int DEFAULT_DATA_WIDTH = 64;

    typedef enum logic [2:0] {
        K_ADD = 3'd0,
        K_SUB = 3'd1,
        K_MUL = 3'd2,
        K_DIV = 3'd3,
        K_MOD = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2,
        ST_INV  = 2'd3
    } t_status;

    // Per-item control that rides alongside the data through the divider
    typedef struct packed {
        t_kind   kind;
        logic    neg_a;
        logic    neg_b;
        logic    b_zero;
        logic    min_by_m1;
        t_status st;
    } t_ctrl;

endpackage

/* rtl/csalu_in_if.sv */
// ----------------------------------------------------------------------------
// csalu_in_if - operation channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface csalu_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [2:0]                                 kind;
    logic signed [csalu_pkg::FIELD_WIDTH-1:0]   first_operand;
    logic signed [csalu_pkg::FIELD_WIDTH-1:0]   second_operand;

    modport source (output valid, kind, first_operand, second_operand, input ready);
    modport sink   (input valid, kind, first_operand, second_operand, output ready);
endinterface

/* rtl/csalu_out_if.sv */
// ----------------------------------------------------------------------------
// csalu_out_if - result channel
// Valid/ready channel carrying one result item with its status.
// ----------------------------------------------------------------------------
interface csalu_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [csalu_pkg::FIELD_WIDTH-1:0]   result;
    logic [1:0]                                 status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

/* rtl/csalu_div_step.sv */
// ----------------------------------------------------------------------------
// csalu_div_step - one registered restoring-division stage
// Retires one quotient bit per stage; other payload passes through.
// ----------------------------------------------------------------------------
module csalu_div_step #(
    parameter int W = csalu_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  csalu_pkg::t_ctrl    i_ctrl,
    input  logic [W-1:0]        i_b,
    input  logic [W-1:0]        i_mb,
    input  logic [W-1:0]        i_rem,
    input  logic [W-1:0]        i_dq,
    input  logic [W-1:0]        i_early,
    output logic                o_valid,
    output csalu_pkg::t_ctrl    o_ctrl,
    output logic [W-1:0]        o_b,
    output logic [W-1:0]        o_mb,
    output logic [W-1:0]        o_rem,
    output logic [W-1:0]        o_dq,
    output logic [W-1:0]        o_early
);
    logic [W:0]   w_trial;
    logic [W:0]   w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_dq;

    logic             r_valid;
    csalu_pkg::t_ctrl r_ctrl;
    logic [W-1:0]     r_b, r_mb, r_rem, r_dq, r_early;

    // shift in next dividend bit, subtract divisor if it fits
    assign w_trial = {i_rem, i_dq[W-1]};
    assign w_diff  = w_trial - {1'b0, i_mb};
    assign w_ge    = (w_trial >= {1'b0, i_mb});
    assign n_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
    assign n_dq    = {i_dq[W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl  <= i_ctrl;
            r_b     <= i_b;
            r_mb    <= i_mb;
            r_rem   <= n_rem;
            r_dq    <= n_dq;
            r_early <= i_early;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_b     = r_b;
    assign o_mb    = r_mb;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_early = r_early;

endmodule

/* rtl/checked_signed_alu_core.sv */
// ----------------------------------------------------------------------------
// checked_signed_alu_core - pipelined checked signed integer ALU
// Add, subtract, multiply, divide and adjusted modulo with status codes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : operation items (kind, first_operand, second_operand). Only the
//           low DATA_WIDTH bits of each operand are used, as two's complement.
//   o_out : one result item per operation, result sign-extended to 64 bits,
//           status 0 ok, 1 overflow, 2 divide by zero, 3 invalid kind.
//           result is zero whenever status is not ok.
// Throughput: one item per cycle, every kind, while the skid is empty. Items leave in arrival order.
// Depth: DATA_WIDTH + 5 register stages, the same for every kind. The
//   divider (one quotient bit per stage, DATA_WIDTH stages) sets that depth.
//   Front stages: operand/magnitude capture, partial products plus add/sub,
//   product sum, multiply check. A fixup stage follows the divider.
// Stall: a one-item skid register behind the pipeline takes the result that
//   the receiver refuses; the pipe keeps moving until the skid is full, then
//   i_in.ready drops until the skid drains.
// Reset: synchronous, active low; clears every valid bit and the skid.
// ----------------------------------------------------------------------------
module checked_signed_alu_core #(
    parameter int DATA_WIDTH = csalu_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csalu_in_if.sink      i_in,
    csalu_out_if.source   o_out
);
    localparam int W  = DATA_WIDTH;
    localparam int FW = csalu_pkg::FIELD_WIDTH;
    // split of the multiplier into four narrow products
    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam logic [2*W-1:0] P_MAG_MIN = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] P_MAG_MAX = P_MAG_MIN - 1'b1;
    localparam logic [W-1:0]   V_MIN     = {1'b1, {(W-1){1'b0}}};

    // global advance: the pipe moves while the skid is empty
    logic w_adv;

    // ------------------------------------------------------------------
    // Stage 1: operand capture, magnitudes, divide special-case flags
    // ------------------------------------------------------------------
    logic [W-1:0] w_a, w_b;
    logic         r_s1_valid;
    csalu_pkg::t_kind r_s1_kind;
    logic [W-1:0] r_s1_a, r_s1_b, r_s1_ma, r_s1_mb;
    logic         r_s1_min_by_m1;

    assign w_a = i_in.first_operand[W-1:0];
    assign w_b = i_in.second_operand[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_kind      <= csalu_pkg::t_kind'(i_in.kind);
            r_s1_a         <= w_a;
            r_s1_b         <= w_b;
            r_s1_ma        <= w_a[W-1] ? (~w_a + 1'b1) : w_a;
            r_s1_mb        <= w_b[W-1] ? (~w_b + 1'b1) : w_b;
            r_s1_min_by_m1 <= (w_a == V_MIN) && (&w_b);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: add/sub with overflow, partial products
    // ------------------------------------------------------------------
    logic [W-1:0]     w_sum, w_dif;
    logic             w_add_ovf, w_sub_ovf;
    logic [W-1:0]     n_s2_res;
    csalu_pkg::t_status n_s2_st;

    logic             r_s2_valid;
    csalu_pkg::t_ctrl r_s2_ctrl;
    logic [W-1:0]     r_s2_b, r_s2_ma, r_s2_mb, r_s2_res;
    logic [2*H-1:0]   r_s2_p_ll;
    logic [W-1:0]     r_s2_p_lh, r_s2_p_hl;
    logic [2*L-1:0]   r_s2_p_hh;

    assign w_sum     = r_s1_a + r_s1_b;
    assign w_dif     = r_s1_a - r_s1_b;
    assign w_add_ovf = (r_s1_a[W-1] == r_s1_b[W-1]) && (w_sum[W-1] != r_s1_a[W-1]);
    assign w_sub_ovf = (r_s1_a[W-1] != r_s1_b[W-1]) && (w_dif[W-1] != r_s1_a[W-1]);

    // early result for kinds that finish here; others fixed later
    always_comb begin
        n_s2_res = '0;
        n_s2_st  = csalu_pkg::ST_OK;
        unique case (r_s1_kind)
            csalu_pkg::K_ADD: begin
                n_s2_st  = w_add_ovf ? csalu_pkg::ST_OVF : csalu_pkg::ST_OK;
                n_s2_res = w_add_ovf ? '0 : w_sum;
            end
            csalu_pkg::K_SUB: begin
                n_s2_st  = w_sub_ovf ? csalu_pkg::ST_OVF : csalu_pkg::ST_OK;
                n_s2_res = w_sub_ovf ? '0 : w_dif;
            end
            csalu_pkg::K_MUL,
            csalu_pkg::K_DIV,
            csalu_pkg::K_MOD: begin
                n_s2_st  = csalu_pkg::ST_OK;
                n_s2_res = '0;
            end
            default: begin
                n_s2_st  = csalu_pkg::ST_INV;
                n_s2_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_ctrl.kind      <= r_s1_kind;
            r_s2_ctrl.neg_a     <= r_s1_a[W-1];
            r_s2_ctrl.neg_b     <= r_s1_b[W-1];
            r_s2_ctrl.b_zero    <= (r_s1_mb == '0);
            r_s2_ctrl.min_by_m1 <= r_s1_min_by_m1;
            r_s2_ctrl.st        <= n_s2_st;
            r_s2_b              <= r_s1_b;
            r_s2_ma             <= r_s1_ma;
            r_s2_mb             <= r_s1_mb;
            r_s2_res            <= n_s2_res;
            r_s2_p_ll           <= r_s1_ma[H-1:0] * r_s1_mb[H-1:0];
            r_s2_p_lh           <= W'(r_s1_ma[H-1:0] * r_s1_mb[W-1:H]);
            r_s2_p_hl           <= W'(r_s1_ma[W-1:H] * r_s1_mb[H-1:0]);
            r_s2_p_hh           <= r_s1_ma[W-1:H] * r_s1_mb[W-1:H];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of partial products
    // ------------------------------------------------------------------
    logic [2*W-1:0]   w_cross;
    logic             r_s3_valid;
    csalu_pkg::t_ctrl r_s3_ctrl;
    logic [W-1:0]     r_s3_b, r_s3_ma, r_s3_mb, r_s3_res;
    logic [2*W-1:0]   r_s3_prod;

    assign w_cross = (2*W)'(r_s2_p_lh) + (2*W)'(r_s2_p_hl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_ctrl <= r_s2_ctrl;
            r_s3_b    <= r_s2_b;
            r_s3_ma   <= r_s2_ma;
            r_s3_mb   <= r_s2_mb;
            r_s3_res  <= r_s2_res;
            r_s3_prod <= (2*W)'(r_s2_p_ll) + (w_cross << H)
                       + ((2*W)'(r_s2_p_hh) << (2*H));
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: multiply range check and sign; divider entry
    // ------------------------------------------------------------------
    logic             w_mul_neg, w_mul_ovf;
    logic [W-1:0]     w_mul_res;
    csalu_pkg::t_ctrl n_s4_ctrl;
    logic [W-1:0]     n_s4_res;

    logic             r_s4_valid;
    csalu_pkg::t_ctrl r_s4_ctrl;
    logic [W-1:0]     r_s4_b, r_s4_ma, r_s4_mb, r_s4_res;

    assign w_mul_neg = r_s3_ctrl.neg_a ^ r_s3_ctrl.neg_b;
    assign w_mul_ovf = w_mul_neg ? (r_s3_prod > P_MAG_MIN) : (r_s3_prod > P_MAG_MAX);
    assign w_mul_res = w_mul_neg ? (~r_s3_prod[W-1:0] + 1'b1) : r_s3_prod[W-1:0];

    always_comb begin
        n_s4_ctrl = r_s3_ctrl;
        n_s4_res  = r_s3_res;
        if (r_s3_ctrl.kind == csalu_pkg::K_MUL) begin
            n_s4_ctrl.st = w_mul_ovf ? csalu_pkg::ST_OVF : csalu_pkg::ST_OK;
            n_s4_res     = w_mul_ovf ? '0 : w_mul_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_ctrl <= n_s4_ctrl;
            r_s4_b    <= r_s3_b;
            r_s4_ma   <= r_s3_ma;
            r_s4_mb   <= r_s3_mb;
            r_s4_res  <= n_s4_res;
        end
    end

    // ------------------------------------------------------------------
    // Divider: W stages, one quotient bit each
    // ------------------------------------------------------------------
    logic             c_valid [W+1];
    csalu_pkg::t_ctrl c_ctrl  [W+1];
    logic [W-1:0]     c_b     [W+1];
    logic [W-1:0]     c_mb    [W+1];
    logic [W-1:0]     c_rem   [W+1];
    logic [W-1:0]     c_dq    [W+1];
    logic [W-1:0]     c_early [W+1];

    assign c_valid[0] = r_s4_valid;
    assign c_ctrl[0]  = r_s4_ctrl;
    assign c_b[0]     = r_s4_b;
    assign c_mb[0]    = r_s4_mb;
    assign c_rem[0]   = '0;
    assign c_dq[0]    = r_s4_ma;
    assign c_early[0] = r_s4_res;

    for (genvar g = 0; g < W; g++) begin : g_div
        csalu_div_step #(.W(W)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (c_valid[g]),
            .i_ctrl  (c_ctrl[g]),
            .i_b     (c_b[g]),
            .i_mb    (c_mb[g]),
            .i_rem   (c_rem[g]),
            .i_dq    (c_dq[g]),
            .i_early (c_early[g]),
            .o_valid (c_valid[g+1]),
            .o_ctrl  (c_ctrl[g+1]),
            .o_b     (c_b[g+1]),
            .o_mb    (c_mb[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_dq    (c_dq[g+1]),
            .o_early (c_early[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Fixup stage: quotient sign, modulo adjustment, final status
    // ------------------------------------------------------------------
    csalu_pkg::t_ctrl   w_fc;
    logic [W-1:0]       w_q, w_mr, w_madj;
    logic               w_madj_ovf;
    logic [W-1:0]       n_fin_res;
    csalu_pkg::t_status n_fin_st;

    logic               r_fin_valid;
    logic [FW-1:0]      r_fin_res;
    csalu_pkg::t_status r_fin_st;

    assign w_fc       = c_ctrl[W];
    assign w_q        = c_dq[W];
    assign w_mr       = c_rem[W];
    // divisor plus negated remainder
    assign w_madj     = c_b[W] - w_mr;
    assign w_madj_ovf = c_b[W][W-1] && !w_madj[W-1];

    always_comb begin
        n_fin_res = c_early[W];
        n_fin_st  = w_fc.st;
        unique case (w_fc.kind)
            csalu_pkg::K_DIV: begin
                if (w_fc.b_zero) begin
                    n_fin_st  = csalu_pkg::ST_DIVZ;
                    n_fin_res = '0;
                end else if (w_fc.min_by_m1) begin
                    n_fin_st  = csalu_pkg::ST_OVF;
                    n_fin_res = '0;
                end else begin
                    n_fin_st  = csalu_pkg::ST_OK;
                    n_fin_res = (w_fc.neg_a ^ w_fc.neg_b) ? (~w_q + 1'b1) : w_q;
                end
            end
            csalu_pkg::K_MOD: begin
                if (w_fc.b_zero) begin
                    n_fin_st  = csalu_pkg::ST_DIVZ;
                    n_fin_res = '0;
                end else if (w_fc.neg_a && (w_mr != '0)) begin
                    n_fin_st  = w_madj_ovf ? csalu_pkg::ST_OVF : csalu_pkg::ST_OK;
                    n_fin_res = w_madj_ovf ? '0 : w_madj;
                end else begin
                    n_fin_st  = csalu_pkg::ST_OK;
                    n_fin_res = w_mr;
                end
            end
            default: begin
                n_fin_res = c_early[W];
                n_fin_st  = w_fc.st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_adv) begin
            r_fin_valid <= c_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin_res <= FW'(signed'(n_fin_res));
            r_fin_st  <= n_fin_st;
        end
    end

    // ------------------------------------------------------------------
    // Skid register: catches the tail item the receiver refuses
    // ------------------------------------------------------------------
    logic               r_skid_valid;
    logic [FW-1:0]      r_skid_res;
    csalu_pkg::t_status r_skid_st;
    logic               w_capture;

    assign w_adv     = !r_skid_valid;
    assign w_capture = !r_skid_valid && r_fin_valid && !o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            r_skid_valid <= !o_out.ready;
        end else begin
            r_skid_valid <= w_capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_skid_res <= r_fin_res;
            r_skid_st  <= r_fin_st;
        end
    end

    assign i_in.ready   = w_adv;
    assign o_out.valid  = r_skid_valid || r_fin_valid;
    assign o_out.result = r_skid_valid ? r_skid_res : r_fin_res;
    assign o_out.status = r_skid_valid ? r_skid_st : r_fin_st;

`ifndef SYNTHESIS
    // failed operations carry a zero result
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != csalu_pkg::ST_OK)) |-> (o_out.result == '0))
        else $error("nonzero result with failing status");

    // result is a sign-extended DATA_WIDTH value
    a_sext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.result[FW-1:W-1] == '0) || (&o_out.result[FW-1:W-1])))
        else $error("result not sign-extended");

    // skid fills only when the receiver stalled a valid tail item
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> ($past(r_fin_valid) && !$past(o_out.ready)))
        else $error("skid filled without a stall");

    // a full skid freezes the pipe and holds the tail
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_out.ready) |=> ($stable(r_fin_valid) && $stable(r_fin_res)))
        else $error("pipe moved while skid was full");
`endif

endmodule

/* tb/csalu_tb_if.sv */
// ----------------------------------------------------------------------------
// csalu_tb_if - testbench package csalu_tb_pkg
// The block's own interface files are used; this file holds the testbench
// time unit and ALU_LATENCY, the depth of the ALU pipeline.
// ----------------------------------------------------------------------------
package csalu_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;
    localparam int ALU_LATENCY = csalu_pkg::DEFAULT_DATA_WIDTH + 5;
endpackage

/* tb/csalu_checker.sv */
// ----------------------------------------------------------------------------
// csalu_checker - result predictor and comparator
// Watches both channels, computes the expected result and status for each
// accepted operation, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module csalu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csalu_in_if         i_in,
    csalu_out_if        i_out,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [63:0]  value;
        csalu_pkg::t_status  status;
    } t_alu_result;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    t_alu_result expected_results[$];

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic t_alu_result compute_alu(logic [2:0] kind, logic [63:0] a,
                                                logic [63:0] b);
        t_alu_result res;
        logic [63:0] ma, mb, q, mr, lim, nr;
        logic [127:0] p;
        logic neg;
        res.value  = '0;
        res.status = csalu_pkg::ST_OK;
        ma = magnitude(a);
        mb = magnitude(b);
        case (kind)
            csalu_pkg::K_ADD: begin
                res.value = a + b;
                if (a[63] == b[63] && res.value[63] != a[63])
                    res.status = csalu_pkg::ST_OVF;
            end
            csalu_pkg::K_SUB: begin
                res.value = a - b;
                if (a[63] != b[63] && res.value[63] != a[63])
                    res.status = csalu_pkg::ST_OVF;
            end
            csalu_pkg::K_MUL: begin
                if (ma != 0 && mb != 0) begin
                    neg = a[63] ^ b[63];
                    lim = neg ? MIN64 : MIN64 - 1;
                    p = ma * mb;
                    if (p > {64'd0, lim}) res.status = csalu_pkg::ST_OVF;
                    else res.value = neg ? -p[63:0] : p[63:0];
                end
            end
            csalu_pkg::K_DIV: begin
                if (mb == 0) res.status = csalu_pkg::ST_DIVZ;
                else if (a == MIN64 && b == '1) res.status = csalu_pkg::ST_OVF;
                else begin
                    q = ma / mb;
                    res.value = (a[63] ^ b[63]) ? -q : q;
                end
            end
            csalu_pkg::K_MOD: begin
                if (mb == 0) res.status = csalu_pkg::ST_DIVZ;
                else begin
                    mr = ma % mb;
                    if (a[63] && mr != 0) begin
                        nr = -mr;
                        res.value = b + nr;
                        // b and -mr both negative can wrap
                        if (b[63] == nr[63] && res.value[63] != b[63])
                            res.status = csalu_pkg::ST_OVF;
                    end else res.value = mr;
                end
            end
            default: res.status = csalu_pkg::ST_INV;
        endcase
        if (res.status != csalu_pkg::ST_OK) res.value = '0;
        return res;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_alu_result exp_r;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(compute_alu(i_in.kind, i_in.first_operand,
                                                       i_in.second_operand));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h status %0d", $time,
                             i_out.result, i_out.status);
                    errs = errs + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== i_out.result) begin
                        $display("%0t: result expected %h actual %h", $time,
                                 exp_r.value, i_out.result);
                        errs = errs + 1;
                    end
                    if (exp_r.status !== i_out.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, i_out.status);
                        errs = errs + 1;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end
endmodule

/* tb/tb_checked_signed_alu_core.sv */
// ----------------------------------------------------------------------------
// tb_checked_signed_alu_core - testbench for the checked signed ALU
// Directed corner operations then random ones, with random idling on both
// channels, a long result hold-off and a drain pause; a checker compares.
// ----------------------------------------------------------------------------
module tb_checked_signed_alu_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = csalu_tb_pkg::ALU_LATENCY;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   mismatch_count;
    int   results_pending;
    bit   steady_phase = 0;   // no idling on either side
    bit   hold_results = 0;   // long receiver hold-off

    csalu_in_if  op_ch();
    csalu_out_if res_ch();

    always #4 i_clk = ~i_clk;

    checked_signed_alu_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (op_ch),
        .o_out  (res_ch)
    );

    csalu_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (op_ch),
        .i_out    (res_ch),
        .o_errors (mismatch_count),
        .o_pending(results_pending)
    );

    initial begin
        op_ch.valid = 1'b0;
        op_ch.kind = '0;
        op_ch.first_operand = '0;
        op_ch.second_operand = '0;
        res_ch.ready = 1'b0;
    end

    // Receiver: random stalls, none in the steady phase, none-ready on hold
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else if (hold_results) res_ch.ready <= 1'b0;
        else res_ch.ready <= steady_phase || ($urandom_range(99) >= 36);
    end

    // Operands biased toward edges: extremes, small values, random
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return MIN64;
            1: return MAX64;
            2: return '1;
            3: return '0;
            4: return 64'(signed'($urandom_range(40)) - 20);
            5: return {32'd0, $urandom()};
            6: return {{32{1'b1}}, $urandom()};
            7: return MIN64 + $urandom_range(3);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Present one operation and hold it until accepted
    task automatic send_op(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
        if (!steady_phase)
            while ($urandom_range(99) < 36) begin
                op_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        op_ch.valid <= 1'b1;
        op_ch.kind <= kind;
        op_ch.first_operand <= a;
        op_ch.second_operand <= b;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        logic [2:0] k;
        logic [63:0] a, b;
        for (int n = 0; n < count; n++) begin
            k = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                          : 3'($urandom_range(4));
            a = pick_operand();
            b = pick_operand();
            // multiply without overflow needs small factors often
            if (k == csalu_pkg::K_MUL && $urandom_range(1)) begin
                a = 64'(signed'($urandom())) ;
                b = 64'(signed'({$urandom_range(3), $urandom()} >>> 2));
            end
            send_op(k, a, b);
        end
    endtask

    task automatic wait_drained();
        op_ch.valid <= 1'b0;
        while (results_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every kind, invalid kinds, special cases
        send_op(csalu_pkg::K_ADD, MAX64, 64'd1);          // add overflow
        send_op(csalu_pkg::K_ADD, MIN64, '1);             // add overflow negative
        send_op(csalu_pkg::K_ADD, MAX64, MIN64);
        send_op(csalu_pkg::K_SUB, MIN64, 64'd1);          // sub overflow
        send_op(csalu_pkg::K_SUB, MAX64, '1);
        send_op(csalu_pkg::K_SUB, '0, MIN64);
        send_op(csalu_pkg::K_MUL, '1, '1);                // two negatives
        send_op(csalu_pkg::K_MUL, MIN64, 64'd1);
        send_op(csalu_pkg::K_MUL, MIN64, '1);             // overflow
        send_op(csalu_pkg::K_MUL, 64'h0000_0001_0000_0000, 64'hffff_ffff_8000_0000);
        send_op(csalu_pkg::K_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
        send_op(csalu_pkg::K_DIV, 64'd7, '0);             // divide by zero
        send_op(csalu_pkg::K_DIV, MIN64, '1);             // minimum over minus one
        send_op(csalu_pkg::K_DIV, -64'd7, 64'd2);
        send_op(csalu_pkg::K_DIV, MAX64, MIN64);
        send_op(csalu_pkg::K_MOD, MIN64, '1);             // modulo gives zero
        send_op(csalu_pkg::K_MOD, -64'd7, 64'd2);         // adjusted remainder
        send_op(csalu_pkg::K_MOD, -64'd7, -64'd2);
        send_op(csalu_pkg::K_MOD, MIN64 + 1, MIN64);      // adjustment out of range
        send_op(csalu_pkg::K_MOD, 64'd5, '0);
        send_op(csalu_pkg::K_MOD, -64'd6, 64'd3);         // zero remainder
        send_op(3'd5, '1, '1);
        send_op(3'd6, '0, '0);
        send_op(3'd7, MAX64, MIN64);

        send_random(200);

        // Steady stretch without idling
        steady_phase = 1;
        send_random(120);
        steady_phase = 0;

        // Sender pause until everything is back
        wait_drained();

        // Receiver holds off while items keep coming, filling the pipe
        fork
            begin
                hold_results = 1;
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_results = 0;
            end
            send_random(130);
        join

        send_random(200);

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("PASS checked_signed_alu_core");
        else
            $display("FAIL checked_signed_alu_core");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL checked_signed_alu_core");
        $finish;
    end
endmodule
